### design/rfo_pkg.sv
// ----------------------------------------------------------------------------
// rfo_pkg
// Shared sizes, request codes and the pipeline record of the ring FIFO
// with overwrite.
// ----------------------------------------------------------------------------
package rfo_pkg;

   // Slot store geometry.
   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // Effective ring length reaches DEPTH itself, so it needs one more bit.
   localparam int LEN_W      = PTR_W + 1;

   // Fixed widths of the register and the reported counts.
   localparam int CSR_LEN_W  = 5;
   localparam int CNT_W      = 4;
   localparam int CNT_MAX    = 15;

   // Request codes; the fourth code is a request that changes nothing.
   localparam logic [1:0] REQ_PUT       = 2'd0;
   localparam logic [1:0] REQ_OVERWRITE = 2'd1;
   localparam logic [1:0] REQ_GET       = 2'd2;

   // Status of an item waiting on its slot read.
   typedef struct packed {
      logic             accepted;
      logic             read_ok;
      logic [CNT_W-1:0] stored_count;
      logic [CNT_W-1:0] free_count;
      logic             overflow_flag;
   } stage_type;

endpackage

### design/ring_fifo_with_overwrite.sv
// ----------------------------------------------------------------------------
// ring_fifo_with_overwrite
// Circular FIFO over a synchronous slot memory, with a plain put that is
// refused when full, an overwrite put that drops the oldest item, a get and
// a sticky overflow flag.
// ----------------------------------------------------------------------------
// The block takes one request per cycle unless the request channel stalls,
// and returns one result per request. An accepted request passes the read of
// the slot memory, whose data is registered, and then the result register.
// Pointers, counts and the overflow flag are updated when a request is
// accepted, so a get right after a put sees that put. The request channel
// stalls only while the result register is full and stalled with another
// item already waiting on its slot read. A write of the ring length empties
// the ring; it is taken whenever no item is waiting on its slot read and no
// request is offered.

module ring_fifo_with_overwrite (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_type,
   input  logic [rfo_pkg::DATA_WIDTH-1:0]    req_write_value,
   // Result channel.
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_accepted,
   output logic [rfo_pkg::DATA_WIDTH-1:0]    rsp_read_value,
   output logic [rfo_pkg::CNT_W-1:0]         rsp_stored_count,
   output logic [rfo_pkg::CNT_W-1:0]         rsp_free_count,
   output logic                              rsp_overflow_flag,
   // Ring length register.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rfo_pkg::CSR_LEN_W-1:0]     csr_ring_length
);

   localparam int PTR_W = rfo_pkg::PTR_W;
   localparam int LEN_W = rfo_pkg::LEN_W;
   localparam int CNT_W = rfo_pkg::CNT_W;
   localparam int DW    = rfo_pkg::DATA_WIDTH;

   logic [rfo_pkg::CSR_LEN_W-1:0] ring_length_ff;
   logic [PTR_W-1:0]              wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]              rd_ptr_ff, rd_ptr_in;
   logic                          overflow_ff, overflow_in;

   logic                          s1_valid_ff, s1_valid_in;
   rfo_pkg::stage_type            s1_ff, s1_in;
   logic                          out_valid_ff, out_valid_in;
   rfo_pkg::stage_type            out_ff;
   logic [DW-1:0]                 out_data_ff;

   logic [DW-1:0]                 slot_mem [rfo_pkg::DEPTH];
   logic [DW-1:0]                 rd_data_ff;
   logic                          mem_wr_en, mem_rd_en;

   logic [LEN_W-1:0]              eff_len;
   logic [LEN_W-1:0]              last_idx;
   logic [PTR_W-1:0]              wr_next, rd_next;
   logic                          ring_full, ring_empty;
   logic [LEN_W-1:0]              held, free;
   logic                          req_take, s1_move, out_load, csr_take;

   // Saturate a count into the reported field width.
   function automatic logic [CNT_W-1:0] sat_count(input logic [LEN_W-1:0] v);
      logic [CNT_W-1:0] r;
      if (int'(v) > rfo_pkg::CNT_MAX) begin
         r = CNT_W'(rfo_pkg::CNT_MAX);
      end else begin
         r = CNT_W'(v);
      end
      return r;
   endfunction

   // Handshakes: requests wait only when both stages are full and stalled.
   // A length write is held off while a request is offered, so the two never
   // meet at one edge.
   assign s1_move   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && out_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = !s1_valid_ff && !req_valid;
   assign csr_take  = csr_valid && csr_ready;

   // Effective ring length, clamped into two to DEPTH.
   always_comb begin
      if (int'(ring_length_ff) < 2) begin
         eff_len = LEN_W'(2);
      end else if (int'(ring_length_ff) > rfo_pkg::DEPTH) begin
         eff_len = LEN_W'(rfo_pkg::DEPTH);
      end else begin
         eff_len = LEN_W'(ring_length_ff);
      end
      last_idx = eff_len - LEN_W'(1);
   end

   // Pointer advance with wrap at the ring end.
   always_comb begin
      wr_next    = ({1'b0, wr_ptr_ff} == last_idx) ? '0 : wr_ptr_ff + PTR_W'(1);
      rd_next    = ({1'b0, rd_ptr_ff} == last_idx) ? '0 : rd_ptr_ff + PTR_W'(1);
      ring_full  = (wr_next == rd_ptr_ff);
      ring_empty = (wr_ptr_ff == rd_ptr_ff);
   end

   // Request decode: new pointers, flag, memory access and counts.
   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      overflow_in = overflow_ff;
      mem_wr_en   = 1'b0;
      mem_rd_en   = 1'b0;
      s1_in       = '0;
      if (req_take) begin
         case (req_type)
            rfo_pkg::REQ_PUT, rfo_pkg::REQ_OVERWRITE: begin
               if (ring_full) begin
                  overflow_in = 1'b1;
               end
               if (!ring_full || req_type == rfo_pkg::REQ_OVERWRITE) begin
                  if (ring_full) begin
                     rd_ptr_in = rd_next;
                  end
                  wr_ptr_in      = wr_next;
                  mem_wr_en      = 1'b1;
                  s1_in.accepted = 1'b1;
               end
            end
            rfo_pkg::REQ_GET: begin
               if (!ring_empty) begin
                  rd_ptr_in      = rd_next;
                  mem_rd_en      = 1'b1;
                  s1_in.accepted = 1'b1;
                  s1_in.read_ok  = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      if (csr_take) begin
         wr_ptr_in = '0;
         rd_ptr_in = '0;
      end

      // Counts after the request.
      if (wr_ptr_in >= rd_ptr_in) begin
         held = LEN_W'(wr_ptr_in) - LEN_W'(rd_ptr_in);
      end else begin
         held = eff_len + LEN_W'(wr_ptr_in) - LEN_W'(rd_ptr_in);
      end
      free                = last_idx - held;
      s1_in.stored_count  = sat_count(held);
      s1_in.free_count    = sat_count(free);
      s1_in.overflow_flag = overflow_in;
   end

   // Slot memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         slot_mem[wr_ptr_ff] <= req_write_value;
      end
      if (mem_rd_en) begin
         rd_data_ff <= slot_mem[rd_ptr_ff];
      end
   end

   // Ring state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_length_ff <= rfo_pkg::CSR_LEN_W'(16);
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         overflow_ff    <= 1'b0;
      end else begin
         if (csr_take) begin
            ring_length_ff <= csr_ring_length;
         end
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         overflow_ff <= overflow_in;
      end
   end

   // Read stage and result register valid control.
   assign out_load     = s1_move;
   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_move);
   assign out_valid_in = out_load || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload of the two stages; the read data is only taken on a good get.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff <= s1_in;
      end
      if (out_load) begin
         out_ff      <= s1_ff;
         out_data_ff <= s1_ff.read_ok ? rd_data_ff : '0;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_accepted      = out_ff.accepted;
   assign rsp_read_value    = out_data_ff;
   assign rsp_stored_count  = out_ff.stored_count;
   assign rsp_free_count    = out_ff.free_count;
   assign rsp_overflow_flag = out_ff.overflow_flag;

   // The overflow flag is sticky until reset.
   a_flag_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(overflow_ff) && !$past(reset) |-> overflow_ff)
      else $error("overflow flag cleared without reset");

   // Both pointers stay inside the ring.
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, wr_ptr_ff} < eff_len) && ({1'b0, rd_ptr_ff} < eff_len))
      else $error("ring pointer beyond ring length");

   // Requests stall only when both stages hold items.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && out_valid_ff)
      else $error("request stalled with room in the pipeline");

   // A failed request never returns data.
   a_no_data_on_fail: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.accepted |-> out_data_ff == '0)
      else $error("read data on a refused request");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ring FIFO with overwrite. A queue of requests
// feeds a clocked driver, a clocked monitor compares every result with a
// behavioral copy of the ring, and the ring length is changed between
// phases while the block is idle. Both channels insert random idle cycles,
// and one phase holds the result channel off long enough to fill the block.
// ----------------------------------------------------------------------------
module testbench;

   // Sizes and request codes of the block.
   localparam int DATA_WIDTH = rfo_pkg::DATA_WIDTH;
   localparam int DEPTH      = rfo_pkg::DEPTH;
   localparam int CNT_W      = rfo_pkg::CNT_W;
   localparam int CNT_MAX    = rfo_pkg::CNT_MAX;
   localparam int CSR_LEN_W  = rfo_pkg::CSR_LEN_W;
   localparam logic [1:0] REQ_PUT       = rfo_pkg::REQ_PUT;
   localparam logic [1:0] REQ_OVERWRITE = rfo_pkg::REQ_OVERWRITE;
   localparam logic [1:0] REQ_GET       = rfo_pkg::REQ_GET;

   // A request code that asks for nothing.
   localparam logic [1:0] REQ_NONE = 2'd3;
   localparam int HOLD_CYCLES  = 64;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 6;
   localparam int PHASE_COUNT  = 12;
   localparam int PHASE_ITEMS  = 170;
   localparam int PRESSURE_PHASE = 2;
   localparam logic [4:0] PHASE_LEN [PHASE_COUNT] =
      '{5'd16, 5'd2, 5'd31, 5'd0, 5'd3, 5'd1, 5'd15, 5'd7, 5'd17, 5'd9, 5'd4, 5'd12};

   typedef struct {
      logic [1:0]            kind;
      logic [DATA_WIDTH-1:0] value;
   } fifo_request_type;

   typedef struct {
      logic                  accepted;
      logic [DATA_WIDTH-1:0] read_value;
      logic [CNT_W-1:0]      stored_count;
      logic [CNT_W-1:0]      free_count;
      logic                  overflow_flag;
   } fifo_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_type = REQ_NONE;
   logic [DATA_WIDTH-1:0] req_write_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_accepted;
   logic [DATA_WIDTH-1:0] rsp_read_value;
   logic [CNT_W-1:0]      rsp_stored_count;
   logic [CNT_W-1:0]      rsp_free_count;
   logic                  rsp_overflow_flag;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_LEN_W-1:0]  csr_ring_length = '0;

   // Requests waiting to be offered and results owed by the block.
   fifo_request_type pending_requests[$];
   fifo_result_type  results_owed[$];

   // Behavioral copy of the ring.
   logic [CSR_LEN_W-1:0]  ring_len_cfg = 5'd16;
   int unsigned           ring_wr = 0;
   int unsigned           ring_rd = 0;
   logic                  ring_overflow = 1'b0;
   logic [DATA_WIDTH-1:0] ring_slots [DEPTH];

   int unsigned error_count = 0;
   int unsigned requests_queued = 0;
   int unsigned requests_taken = 0;
   int unsigned full_puts = 0;
   int unsigned empty_gets = 0;
   int unsigned input_stall_cycles = 0;
   int unsigned send_gap_max = 0;
   int unsigned sink_gap_max = 0;
   logic        hold_armed = 1'b0;

   ring_fifo_with_overwrite i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_write_value   (req_write_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_accepted      (rsp_accepted),
      .rsp_read_value    (rsp_read_value),
      .rsp_stored_count  (rsp_stored_count),
      .rsp_free_count    (rsp_free_count),
      .rsp_overflow_flag (rsp_overflow_flag),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_ring_length   (csr_ring_length)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Next position of a pointer within a ring of the given length.
   function automatic int unsigned ring_next(int unsigned ptr, int unsigned len);
      return (ptr + 1 >= len) ? 0 : ptr + 1;
   endfunction

   // Applies one request to the ring copy and returns the result it owes.
   function automatic fifo_result_type fifo_apply(fifo_request_type req);
      fifo_result_type res;
      int unsigned     len;
      int unsigned     nxt;
      int unsigned     held;
      len = (ring_len_cfg < 2) ? 2 : (ring_len_cfg > DEPTH) ? DEPTH : ring_len_cfg;
      res = '{default: '0};
      if (req.kind == REQ_PUT || req.kind == REQ_OVERWRITE) begin
         nxt = ring_next(ring_wr, len);
         if (nxt == ring_rd) begin
            ring_overflow = 1'b1;
            full_puts++;
         end
         if (nxt != ring_rd || req.kind == REQ_OVERWRITE) begin
            // An overwrite on a full ring drops the oldest item first.
            if (nxt == ring_rd)
               ring_rd = ring_next(ring_rd, len);
            ring_slots[ring_wr] = req.value;
            ring_wr = nxt;
            res.accepted = 1'b1;
         end
      end else if (req.kind == REQ_GET) begin
         if (ring_wr != ring_rd) begin
            res.read_value = ring_slots[ring_rd];
            ring_rd = ring_next(ring_rd, len);
            res.accepted = 1'b1;
         end else begin
            empty_gets++;
         end
      end
      held = (len + ring_wr - ring_rd) % len;
      res.stored_count  = CNT_W'((held > CNT_MAX) ? CNT_MAX : held);
      res.free_count    = CNT_W'((len - 1 - held > CNT_MAX) ? CNT_MAX : len - 1 - held);
      res.overflow_flag = ring_overflow;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [DATA_WIDTH-1:0] want,
                              input logic [DATA_WIDTH-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   // Request driver: offers queued items, waiting a random number of
   // cycles after each one, and never changes a stalled item.
   int unsigned send_wait = 0;
   always @(posedge clock) begin
      fifo_request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_valid && !req_stall) begin
            results_owed.push_back(fifo_apply('{req_type, req_write_value}));
            requests_taken++;
         end
         if (req_valid && req_stall)
            input_stall_cycles++;
         if (!req_valid || !req_stall) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               next_req = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_type <= next_req.kind;
               req_write_value <= next_req.value;
               send_wait = $urandom_range(0, send_gap_max);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each result against the oldest one owed, then
   // stalls for a random number of cycles, or for a long hold when armed.
   int unsigned sink_wait = 0;
   int unsigned hold_left = 0;
   logic        hold_taken = 1'b0;
   always @(posedge clock) begin
      fifo_result_type due;
      if (reset) begin
         rsp_stall <= 1'b0;
         sink_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (results_owed.size() == 0) begin
               $error("result arrived with no request outstanding");
               error_count++;
            end else begin
               due = results_owed.pop_front();
               check_field("accepted", DATA_WIDTH'(due.accepted),
                           DATA_WIDTH'(rsp_accepted));
               check_field("read_value", due.read_value, rsp_read_value);
               check_field("stored_count", DATA_WIDTH'(due.stored_count),
                           DATA_WIDTH'(rsp_stored_count));
               check_field("free_count", DATA_WIDTH'(due.free_count),
                           DATA_WIDTH'(rsp_free_count));
               check_field("overflow_flag", DATA_WIDTH'(due.overflow_flag),
                           DATA_WIDTH'(rsp_overflow_flag));
            end
            sink_wait = $urandom_range(0, sink_gap_max);
         end
         if (hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (sink_wait > 0) begin
            sink_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: ends the run when no channel moves for too long.
   int unsigned quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout after %0d cycles with no transfer.", QUIET_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic queue_item(input logic [1:0] kind, input logic [DATA_WIDTH-1:0] value);
      pending_requests.push_back('{kind, value});
      requests_queued++;
   endtask

   // Waits until every queued item has been taken and answered, then lets
   // the block settle.
   task automatic wait_until_idle();
      while (requests_taken != requests_queued || results_owed.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes the ring length; the ring copy empties as the block does.
   task automatic write_ring_length(input logic [CSR_LEN_W-1:0] len);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_ring_length <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      ring_len_cfg = len;
      ring_wr = 0;
      ring_rd = 0;
   endtask

   // Picks a gap limit: no idling, the widest gaps, or something between.
   function automatic int unsigned pick_gap_max();
      int unsigned sel;
      sel = $urandom_range(0, 2);
      return (sel == 0) ? 0 : (sel == 1) ? 8 : $urandom_range(0, 8);
   endfunction

   // Stimulus sequence.
   initial begin
      logic [CSR_LEN_W-1:0]  len;
      logic [DATA_WIDTH-1:0] value;
      logic [1:0]            kind;
      int unsigned           put_pct;
      int unsigned           pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset length, empty get, extreme values, unused code.
      send_gap_max = pick_gap_max();
      sink_gap_max = pick_gap_max();
      queue_item(REQ_GET, 32'h0);
      queue_item(REQ_PUT, 32'h0);
      queue_item(REQ_PUT, 32'hFFFF_FFFF);
      queue_item(REQ_PUT, 32'hA5A5_A5A5);
      queue_item(REQ_NONE, 32'h1234_5678);
      queue_item(REQ_GET, 32'hFFFF_FFFF);
      queue_item(REQ_GET, 32'h0);
      queue_item(REQ_GET, 32'h0);
      queue_item(REQ_GET, 32'h0);
      wait_until_idle();

      // Directed: smallest ring, refused put, overwrite of the oldest item.
      write_ring_length(5'd2);
      queue_item(REQ_PUT, 32'h1);
      queue_item(REQ_PUT, 32'h2);
      queue_item(REQ_OVERWRITE, 32'h3);
      queue_item(REQ_GET, 32'h0);
      queue_item(REQ_GET, 32'h0);
      queue_item(REQ_OVERWRITE, 32'h4);
      queue_item(REQ_GET, 32'h0);
      wait_until_idle();

      // Directed: lengths below and above the legal range saturate.
      write_ring_length(5'd0);
      queue_item(REQ_PUT, 32'h5A5A_5A5A);
      queue_item(REQ_OVERWRITE, 32'h8000_0001);
      queue_item(REQ_GET, 32'h0);
      wait_until_idle();
      write_ring_length(5'd31);
      queue_item(REQ_PUT, 32'h7FFF_FFFF);
      queue_item(REQ_GET, 32'h0);
      wait_until_idle();

      // Random phases, each with its own ring length and idling pattern.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         len = (phase >= 9) ? CSR_LEN_W'($urandom_range(0, 31)) : PHASE_LEN[phase];
         write_ring_length(len);
         if (phase == PRESSURE_PHASE) begin
            send_gap_max = 0;
            sink_gap_max = 0;
         end else begin
            send_gap_max = pick_gap_max();
            sink_gap_max = pick_gap_max();
         end
         put_pct = 50;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Swing between filling, draining and mixed stretches.
            if (n % 24 == 0) begin
               pick = $urandom_range(0, 2);
               put_pct = (pick == 0) ? 80 : (pick == 1) ? 20 : 50;
            end
            pick = $urandom_range(0, 99);
            if (pick < 3)
               kind = REQ_NONE;
            else if (pick < 3 + put_pct)
               kind = ($urandom_range(0, 1) != 0) ? REQ_OVERWRITE : REQ_PUT;
            else
               kind = REQ_GET;
            pick = $urandom_range(0, 9);
            value = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
            queue_item(kind, value);
         end
         // Hold the result side off while the sender keeps offering.
         if (phase == PRESSURE_PHASE)
            hold_armed = 1'b1;
         wait_until_idle();
      end

      $display("Ran %0d requests over %0d ring lengths, including saturated ones.",
               requests_taken, PHASE_COUNT + 4);
      $display("Saw %0d puts on a full ring, %0d gets on an empty ring, %0d stalled input cycles.",
               full_puts, empty_gets, input_stall_cycles);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
